@@ hdl/dscmp_pkg.sv @@
// Package: constants, types and helpers for the dice sum matrix power block.
package dscmp_pkg;

  localparam int unsigned Faces    = 6;
  localparam int unsigned Cells    = Faces * Faces;
  localparam int unsigned CellW    = $clog2(Cells);
  localparam int unsigned IdxW     = $clog2(Faces);
  localparam int unsigned InW      = 63;
  localparam int unsigned OutW     = 30;
  localparam logic [29:0] Modulus  = 30'd1000000007;
  // Barrett factor floor(2^60 / p)
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'd1000000007);

  typedef logic [InW-1:0]  sum_t;
  typedef logic [OutW-1:0] val_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [1:0] {
    MAT_ACC = 2'd0,
    MAT_SQR = 2'd1,
    MAT_SCR = 2'd2
  } mat_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL_ACC,
    ST_CPY_ACC,
    ST_MUL_SQR,
    ST_CPY_SQR,
    ST_SHIFT,
    ST_FINAL,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT,
    CMD_MUL,
    CMD_COPY,
    CMD_SHIFT,
    CMD_FINAL
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    cmd_e     cmd;
    mat_sel_e dst;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic short_n;   // n <= Faces, answer is a power of two
    logic exp_zero;
    logic exp_lsb;
    logic done;      // current multi-cycle command finished
  } stat_t;

  // 2^e mod p for e < Faces, fits far below the modulus
  function automatic val_t pow2(input idx_t e);
    pow2 = val_t'(1) << e;
  endfunction

  // companion matrix entry at a flat cell address
  function automatic val_t init_base(input logic [CellW-1:0] a);
    init_base = '0;
    for (int r = 0; r < Faces; r++) begin
      for (int c = 0; c < Faces; c++) begin
        if ((r == 0 || r == c + 1) && a == CellW'(r * Faces + c)) init_base = val_t'(1);
      end
    end
  endfunction

  // identity matrix entry at a flat cell address
  function automatic val_t init_ident(input logic [CellW-1:0] a);
    init_ident = '0;
    for (int r = 0; r < Faces; r++) begin
      if (a == CellW'(r * Faces + r)) init_ident = val_t'(1);
    end
  endfunction

endpackage

@@ hdl/dscmp_if.sv @@
// Valid/ready stream interface carrying one payload word per beat.
interface dscmp_if #(parameter int unsigned W = 1) (input logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/dscmp_modmul.sv @@
// Modular multiplier: registered 30x30 product, Barrett reduction, four stages.
module dscmp_modmul (
  input  logic               clk_i,
  input  dscmp_pkg::val_t    a_i,
  input  dscmp_pkg::val_t    b_i,
  output dscmp_pkg::val_t    p_o
);
  import dscmp_pkg::*;

  logic [59:0] prod_q;
  logic [59:0] x1_q;
  logic [61:0] q2_q;
  logic [31:0] x2_q;
  logic [31:0] qp_q;
  logic [31:0] r_q;
  logic [31:0] r1;
  logic [31:0] r2;

  // stage 1: raw product
  always_ff @(posedge clk_i) begin
    prod_q <= 60'(a_i) * 60'(b_i);
  end

  // stage 2: quotient estimate (x >> 29) * mu
  always_ff @(posedge clk_i) begin
    x1_q <= prod_q;
    q2_q <= 62'(prod_q[59:29]) * 62'(BarrettMu);
  end

  // stage 3: quotient times modulus, low 32 bits are enough
  always_ff @(posedge clk_i) begin
    x2_q <= x1_q[31:0];
    qp_q <= 32'(q2_q[61:31]) * 32'(Modulus);
  end

  // stage 4: remainder below 3p
  always_ff @(posedge clk_i) begin
    r_q <= x2_q - qp_q;
  end

  // two conditional subtractions
  assign r1  = (r_q >= 32'(Modulus)) ? r_q - 32'(Modulus) : r_q;
  assign r2  = (r1 >= 32'(Modulus)) ? r1 - 32'(Modulus) : r1;
  assign p_o = r2[29:0];

endmodule

@@ hdl/dscmp_datapath.sv @@
// Datapath: matrix stores, shared modular multiplier, accumulator, exponent.
module dscmp_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dscmp_pkg::ctrl_t  ctrl_i,
  input  dscmp_pkg::sum_t   target_sum_i,
  output dscmp_pkg::stat_t  stat_o,
  output dscmp_pkg::val_t   way_count_o
);
  import dscmp_pkg::*;

  // operand register plus four multiplier stages
  localparam int unsigned Lat = 5;

  val_t acc_mem [Cells];
  val_t sqr_mem [Cells];
  val_t scr_mem [Cells];

  sum_t exp_q, exp_d;
  logic short_q, short_d;

  // loop counters: i, j, k issue side
  idx_t i_q, j_q, k_q;
  idx_t i_d, j_d, k_d;
  logic issue_q, issue_d;
  // pipeline tags for writeback
  logic [Lat-1:0] vld_q, vld_d;
  logic [Lat-1:0] last_q;
  logic [Lat-1:0] first_q;
  logic [CellW-1:0] wadr_q [Lat];
  val_t sum_q;
  val_t ra_q, rb_q;
  logic [CellW-1:0] cpy_q, cpy_d;
  logic done_q, done_d;
  val_t out_q;

  // operand addresses
  logic [CellW-1:0] adr_a, adr_b, adr_w;
  val_t fin_coef;
  assign adr_a = CellW'(int'(i_q) * Faces + int'(k_q));
  assign adr_b = CellW'(int'(k_q) * Faces + int'(j_q));
  assign adr_w = CellW'(int'(i_q) * Faces + int'(j_q));
  assign fin_coef = pow2(idx_t'(Faces - 1 - int'(k_q)));

  // registered operand reads per command
  always_ff @(posedge clk_i) begin
    ra_q <= (ctrl_i.cmd == CMD_FINAL || ctrl_i.dst == MAT_ACC) ? acc_mem[adr_a]
                                                                : sqr_mem[adr_a];
    rb_q <= (ctrl_i.cmd == CMD_FINAL) ? fin_coef : sqr_mem[adr_b];
  end

  val_t prod;
  dscmp_modmul u_mul (.clk_i(clk_i), .a_i(ra_q), .b_i(rb_q), .p_o(prod));

  // sum with modular correction
  val_t sum_in, sum_nx;
  logic [30:0] sum_raw;
  assign sum_in = first_q[Lat-1] ? '0 : sum_q;
  assign sum_raw = 31'(sum_in) + 31'(prod);
  assign sum_nx = (sum_raw >= 31'(Modulus)) ? val_t'(sum_raw - 31'(Modulus))
                                            : sum_raw[29:0];

  // exponent update
  always_comb begin
    exp_d = exp_q;
    if (ctrl_i.cmd == CMD_LOAD) begin
      exp_d = (target_sum_i > sum_t'(Faces)) ? target_sum_i - sum_t'(Faces) : '0;
    end else if (ctrl_i.cmd == CMD_SHIFT) begin
      exp_d = exp_q >> 1;
    end
  end

  // loop counters, issue and done sequencing
  always_comb begin
    short_d = short_q;
    issue_d = issue_q;
    vld_d   = {vld_q[Lat-2:0], issue_q};
    done_d  = 1'b0;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    cpy_d   = cpy_q;
    if (ctrl_i.cmd == CMD_LOAD) begin
      short_d = (target_sum_i <= sum_t'(Faces));
      issue_d = 1'b0;
      i_d = '0; j_d = '0; k_d = '0; cpy_d = '0;
    end
    // issue i,j,k triples; for final only i=0, j=0
    if ((ctrl_i.cmd == CMD_MUL || ctrl_i.cmd == CMD_FINAL) && !done_q) begin
      if (!issue_q && vld_q == '0 && !(i_q == '0 && j_q == '0 && k_q == '0)) begin
        // all issued and drained
        done_d = 1'b1;
        i_d = '0; j_d = '0; k_d = '0;
      end else if (!issue_q && vld_q == '0) begin
        issue_d = 1'b1;
      end else if (issue_q) begin
        if (k_q != idx_t'(Faces - 1)) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          if (ctrl_i.cmd == CMD_FINAL || j_q == idx_t'(Faces - 1)) begin
            if (ctrl_i.cmd == CMD_FINAL || i_q == idx_t'(Faces - 1)) begin
              i_d = '0;
              issue_d = 1'b0;
              // mark non-zero so drain check distinguishes restart
              j_d = idx_t'(1);
            end else begin
              i_d = i_q + 1'b1;
              j_d = '0;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
    end
    // one cell per cycle for setup and copies
    if ((ctrl_i.cmd == CMD_COPY || ctrl_i.cmd == CMD_INIT) && !done_q) begin
      if (cpy_q == CellW'(Cells - 1)) begin
        cpy_d  = '0;
        done_d = 1'b1;
      end else begin
        cpy_d = cpy_q + 1'b1;
      end
    end
    if (done_q) begin
      i_d = '0; j_d = '0; k_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= '0;
      short_q <= 1'b0;
      issue_q <= 1'b0;
      vld_q   <= '0;
      done_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      cpy_q   <= '0;
    end else begin
      exp_q   <= exp_d;
      short_q <= short_d;
      issue_q <= issue_d;
      vld_q   <= vld_d;
      done_q  <= done_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      cpy_q   <= cpy_d;
    end
  end

  // writeback tags follow the multiplier pipeline (operand reg + Lat-1 stages)
  always_ff @(posedge clk_i) begin
    first_q <= {first_q[Lat-2:0], issue_q && k_q == '0};
    last_q  <= {last_q[Lat-2:0], issue_q && k_q == idx_t'(Faces - 1)};
    wadr_q[0] <= adr_w;
    for (int s = 1; s < Lat; s++) wadr_q[s] <= wadr_q[s-1];
    if (vld_q[Lat-1]) sum_q <= sum_nx;
    if (ctrl_i.cmd == CMD_LOAD && target_sum_i == '0) out_q <= val_t'(1);
    else if (ctrl_i.cmd == CMD_LOAD) out_q <= pow2(idx_t'(target_sum_i - 1'b1));
    if (ctrl_i.cmd == CMD_FINAL && vld_q[Lat-1] && last_q[Lat-1]) out_q <= sum_nx;
  end

  // matrix stores
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_INIT && !done_q) begin
      sqr_mem[cpy_q] <= init_base(cpy_q);
      acc_mem[cpy_q] <= init_ident(cpy_q);
    end
    if (ctrl_i.cmd == CMD_MUL && vld_q[Lat-1] && last_q[Lat-1]) begin
      scr_mem[wadr_q[Lat-1]] <= sum_nx;
    end
    if (ctrl_i.cmd == CMD_COPY && !done_q) begin
      if (ctrl_i.dst == MAT_ACC) acc_mem[cpy_q] <= scr_mem[cpy_q];
      else                       sqr_mem[cpy_q] <= scr_mem[cpy_q];
    end
  end

  assign stat_o.short_n  = short_q;
  assign stat_o.exp_zero = (exp_q == '0);
  assign stat_o.exp_lsb  = exp_q[0];
  assign stat_o.done     = done_q;
  assign way_count_o     = out_q;

endmodule

@@ hdl/dscmp_ctrl.sv @@
// Controller: sequences square-and-multiply over the datapath.
module dscmp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dscmp_pkg::stat_t  stat_i,
  output dscmp_pkg::ctrl_t  ctrl_o
);
  import dscmp_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_INIT;
      ST_INIT:    if (stat_i.short_n) state_d = ST_OUT;
                  else if (stat_i.done) state_d = ST_SHIFT;
      ST_SHIFT:   if (stat_i.exp_zero) state_d = ST_FINAL;
                  else if (stat_i.exp_lsb) state_d = ST_MUL_ACC;
                  else state_d = ST_MUL_SQR;
      ST_MUL_ACC: if (stat_i.done) state_d = ST_CPY_ACC;
      ST_CPY_ACC: if (stat_i.done) state_d = ST_MUL_SQR;
      ST_MUL_SQR: if (stat_i.done) state_d = ST_CPY_SQR;
      ST_CPY_SQR: if (stat_i.done) state_d = ST_SHIFT;
      ST_FINAL:   if (stat_i.done) state_d = ST_OUT;
      ST_OUT:     if (out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs; ST_SHIFT is entered first from INIT without shifting
  always_comb begin
    ctrl_o.cmd = CMD_NONE;
    ctrl_o.dst = MAT_ACC;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE:    begin in_ready_o = 1'b1; if (in_valid_i) ctrl_o.cmd = CMD_LOAD; end
      ST_INIT:    ctrl_o.cmd = stat_i.short_n ? CMD_NONE : CMD_INIT;
      ST_SHIFT:   ctrl_o.cmd = CMD_NONE;
      ST_MUL_ACC: begin ctrl_o.cmd = CMD_MUL; ctrl_o.dst = MAT_ACC; end
      ST_CPY_ACC: begin ctrl_o.cmd = CMD_COPY; ctrl_o.dst = MAT_ACC; end
      ST_MUL_SQR: begin ctrl_o.cmd = CMD_MUL; ctrl_o.dst = MAT_SQR; end
      ST_CPY_SQR: begin
        ctrl_o.dst = MAT_SQR;
        ctrl_o.cmd = stat_i.done ? CMD_SHIFT : CMD_COPY;
      end
      ST_FINAL:   ctrl_o.cmd = CMD_FINAL;
      ST_OUT:     out_valid_o = 1'b1;
      default:    ctrl_o.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/dice_sum_count_matrix_power.sv @@
// Top level: dice sum counter by companion matrix power modulo 1000000007.
//
//   channel   dir  beat payload
//   in_if     in   target_sum (63 bits)
//   out_if    out  way_count  (30 bits)
//
// One item at a time. For n <= 6 the result beat is offered straight after the INIT
// state, with no matrix work. Larger n: a setup that fills the matrices, then per
// exponent bit a squaring, a copy and a shift, plus a product and copy for each one
// bit, and a final row product. Reset clears control only; matrices are rewritten
// per item. A stalled result holds and blocks the next item.
module dice_sum_count_matrix_power (
  input  logic clk_i,
  input  logic rst_ni,
  dscmp_if.sink   in_if,
  dscmp_if.source out_if
);
  import dscmp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  val_t  way_count;

  dscmp_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  dscmp_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl),
    .target_sum_i(sum_t'(in_if.data)), .stat_o(stat), .way_count_o(way_count)
  );

  assign out_if.data = way_count;

endmodule
